// ===== rtl/core/ps2dl_pkg.sv =====
// Shared types and constants for the PS/2 device link core.
`default_nettype none
package ps2dl_pkg;

	localparam logic [3:0] FRAME_BITS = 4'd11;
	localparam logic [3:0] PARITY_BIT = 4'd9;
	localparam logic [3:0] LAST_DATA_BIT = 4'd8;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_RECV = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DATA_LEVEL = 2'd1;
	localparam logic [1:0] ST_CLOCK_LOW = 2'd2;
	localparam logic [1:0] ST_PARITY = 2'd3;

	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_SEND_WAIT = 2'd1;
	localparam logic [1:0] REG_RECV_WAIT = 2'd2;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd20;
	localparam logic [7:0] SEND_WAIT_RST = 8'd30;
	localparam logic [11:0] RECV_WAIT_RST = 12'd250;

	typedef enum logic [5:0] {
		MODE_IDLE      = 6'b000001,
		MODE_SEND_WAIT = 6'b000010,
		MODE_SEND_BITS = 6'b000100,
		MODE_SEND_TAIL = 6'b001000,
		MODE_RECV_WAIT = 6'b010000,
		MODE_RECV_BITS = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [7:0]  half_period_ticks;
		logic [7:0]  send_clock_wait;
		logic [11:0] recv_clock_wait;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       clock_line;
		logic       data_line;
		logic [7:0] send_byte;
	} in_word_t;

	typedef struct packed {
		logic       clock_pull_low;
		logic       data_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] received_byte;
	} out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/ps2dl_in_if.sv =====
// Input word channel: valid/ready handshake with opcode, sampled line levels and send byte as payload.
`default_nettype none
interface ps2dl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       clock_line;
	logic       data_line;
	logic [7:0] send_byte;

	modport source (output valid, output opcode, output clock_line, output data_line,
		output send_byte, input ready);
	modport sink (input valid, input opcode, input clock_line, input data_line,
		input send_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ps2dl_out_if.sv =====
// Result word channel: valid/ready handshake with line drive and transfer status.
`default_nettype none
interface ps2dl_out_if;
	logic       valid;
	logic       ready;
	logic       clock_pull_low;
	logic       data_pull_low;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] received_byte;

	modport source (output valid, output clock_pull_low, output data_pull_low,
		output busy_res, output done_res, output status, output received_byte, input ready);
	modport sink (input valid, input clock_pull_low, input data_pull_low,
		input busy_res, input done_res, input status, input received_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ps2dl_engine.sv =====
// Link sequencer: transfer state, tick counters and bit shifter, one step per word.
`default_nettype none
module ps2dl_engine
	import ps2dl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_word_t  item,
	input  wire cfg_t      cfg,
	output out_word_t      res
);

	mode_t       mode_q, mode_d;
	logic [3:0]  bit_q, bit_d;
	logic [11:0] phase_q, phase_d;
	logic [11:0] wait_q, wait_d;
	logic [7:0]  shift_q, shift_d;
	logic [1:0]  par_q, par_d;
	logic        rxp_q, rxp_d;
	logic [1:0]  drive_q, drive_d;

	logic        done;
	logic [1:0]  st;
	logic [7:0]  rbyte;
	logic [7:0]  hp_eff;
	logic [11:0] hp_w;
	logic [11:0] hp2_w;
	logic [11:0] hp3_w;
	logic [11:0] hp4_w;
	logic [11:0] phase_inc;
	logic        bit_end;
	logic [3:0]  bit_m1;
	logic        tx_bit;

	// zero half period behaves as one tick
	assign hp_eff    = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
	assign hp_w      = {4'd0, hp_eff};
	assign hp2_w     = {3'd0, hp_eff, 1'b0};
	assign hp3_w     = hp2_w + hp_w;
	assign hp4_w     = {2'd0, hp_eff, 2'b00};
	assign phase_inc = phase_q + 12'd1;
	assign bit_end   = (phase_inc >= hp4_w);
	assign bit_m1    = bit_q - 4'd1;

	always_comb begin
		if (bit_q == 4'd0) begin
			tx_bit = 1'b0;
		end else if (bit_q <= LAST_DATA_BIT) begin
			tx_bit = shift_q[bit_m1[2:0]];
		end else if (bit_q == PARITY_BIT) begin
			tx_bit = par_q[0];
		end else begin
			tx_bit = par_q[1];
		end
	end

	always_comb begin
		mode_d    = mode_q;
		bit_d     = bit_q;
		phase_d   = phase_q;
		wait_d    = wait_q;
		shift_d   = shift_q;
		par_d     = par_q;
		rxp_d     = rxp_q;
		drive_d   = drive_q;
		done      = 1'b0;
		st        = ST_OK;
		rbyte     = 8'd0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (item.opcode == OP_SEND) begin
					if (!item.data_line) begin
						done = 1'b1;
						st   = ST_DATA_LEVEL;
					end else begin
						shift_d = item.send_byte;
						par_d   = {1'b1, ~(^item.send_byte)};
						phase_d = 12'd0;
						bit_d   = 4'd0;
						wait_d  = 12'd0;
						mode_d  = item.clock_line ? MODE_SEND_BITS : MODE_SEND_WAIT;
					end
				end else if (item.opcode == OP_RECV) begin
					if (item.data_line) begin
						done = 1'b1;
						st   = ST_DATA_LEVEL;
					end else begin
						shift_d = 8'd0;
						par_d   = 2'b01;
						rxp_d   = 1'b0;
						phase_d = 12'd0;
						bit_d   = 4'd0;
						wait_d  = 12'd0;
						mode_d  = item.clock_line ? MODE_RECV_BITS : MODE_RECV_WAIT;
					end
				end
			end
			MODE_SEND_WAIT: begin
				phase_d = phase_inc;
				if (phase_inc >= hp_w) begin
					phase_d = 12'd0;
					wait_d  = wait_q + 12'd1;
					if (wait_d > {4'd0, cfg.send_clock_wait}) begin
						mode_d = MODE_IDLE;
						done   = 1'b1;
						st     = ST_CLOCK_LOW;
					end else if (item.clock_line) begin
						mode_d = MODE_SEND_BITS;
						bit_d  = 4'd0;
					end
				end
			end
			MODE_SEND_BITS: begin
				drive_d = {~tx_bit, (phase_q >= hp_w) && (phase_q < hp3_w)};
				phase_d = phase_inc;
				if (bit_end) begin
					phase_d = 12'd0;
					if (bit_q == FRAME_BITS - 4'd1) begin
						mode_d = MODE_SEND_TAIL;
						bit_d  = 4'd0;
					end else begin
						bit_d = bit_q + 4'd1;
					end
				end
			end
			MODE_SEND_TAIL: begin
				drive_d = 2'b00;
				phase_d = phase_inc;
				if (bit_end) begin
					phase_d = 12'd0;
					mode_d  = MODE_IDLE;
					done    = 1'b1;
				end
			end
			MODE_RECV_WAIT: begin
				wait_d = wait_q + 12'd1;
				if (wait_d >= cfg.recv_clock_wait) begin
					mode_d = MODE_IDLE;
					done   = 1'b1;
					st     = ST_CLOCK_LOW;
				end else if (item.clock_line) begin
					mode_d  = MODE_RECV_BITS;
					bit_d   = 4'd0;
					phase_d = 12'd0;
				end
			end
			MODE_RECV_BITS: begin
				if (bit_q >= FRAME_BITS) begin
					drive_d = 2'b00;
					mode_d  = MODE_IDLE;
					bit_d   = 4'd0;
					done    = 1'b1;
					rbyte   = shift_q;
					st      = (par_q[0] != rxp_q) ? ST_PARITY : ST_OK;
				end else begin
					// sample on the first tick after the rising clock edge
					if (phase_q == 12'd0) begin
						if (bit_q >= 4'd1 && bit_q <= LAST_DATA_BIT) begin
							shift_d = {item.data_line, shift_q[7:1]};
							par_d   = {par_q[1], par_q[0] ^ item.data_line};
						end else if (bit_q == PARITY_BIT) begin
							rxp_d = item.data_line;
						end
					end
					drive_d = {bit_q == FRAME_BITS - 4'd1, phase_q >= hp2_w};
					phase_d = phase_inc;
					if (bit_end) begin
						phase_d = 12'd0;
						bit_d   = bit_q + 4'd1;
					end
				end
			end
			default: begin
				mode_d  = MODE_IDLE;
				drive_d = 2'b00;
			end
		endcase
	end

	always_comb begin
		res.clock_pull_low = drive_d[0];
		res.data_pull_low  = drive_d[1];
		res.busy_res       = (mode_d != MODE_IDLE);
		res.done_res       = done;
		res.status         = st;
		res.received_byte  = rbyte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			bit_q     <= 4'd0;
			phase_q   <= 12'd0;
			wait_q    <= 12'd0;
			shift_q   <= 8'd0;
			par_q     <= 2'd0;
			rxp_q     <= 1'b0;
			drive_q   <= 2'b00;
		end else if (step) begin
			mode_q    <= mode_d;
			bit_q     <= bit_d;
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			shift_q   <= shift_d;
			par_q     <= par_d;
			rxp_q     <= rxp_d;
			drive_q   <= drive_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ps2_device_link_core.sv =====
// Top level of the PS/2 device link: config registers, input stage, engine, result stage.
// A word waits in the input stage; the engine steps on it as its result is registered.
// Throughput: one word per cycle while results are taken; the engine steps once per word.
// Ready drops only when both the input stage and the result register are held.
// Reset (arst_n low, asynchronous): link idle, lines released, counters and shifter cleared,
// registers back to 20 / 30 / 250, both stages empty.
`default_nettype none
module ps2_device_link_core
	import ps2dl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	ps2dl_in_if.sink         item,
	ps2dl_out_if.source      result,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [11:0] wr_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t out_word_q;
	out_word_t eng_res;
	logic      out_free;
	logic      advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.send_clock_wait   <= SEND_WAIT_RST;
			cfg_q.recv_clock_wait   <= RECV_WAIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= wr_data[7:0];
				REG_SEND_WAIT:   cfg_q.send_clock_wait   <= wr_data[7:0];
				REG_RECV_WAIT:   cfg_q.recv_clock_wait   <= wr_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !out_valid_q || result.ready;
	assign advance_s1 = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			word_s1.opcode     <= item.opcode;
			word_s1.clock_line <= item.clock_line;
			word_s1.data_line  <= item.data_line;
			word_s1.send_byte  <= item.send_byte;
		end
	end

	ps2dl_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.item   (word_s1),
		.cfg    (cfg_q),
		.res    (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_word_q <= eng_res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.clock_pull_low = out_word_q.clock_pull_low;
	assign result.data_pull_low  = out_word_q.data_pull_low;
	assign result.busy_res       = out_word_q.busy_res;
	assign result.done_res       = out_word_q.done_res;
	assign result.status         = out_word_q.status;
	assign result.received_byte  = out_word_q.received_byte;

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> out_valid_q)
		else $error("engine step lost its result word");

	a_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && valid_s1 |-> advance_s1)
		else $error("input stage overwritten before the engine stepped");

	a_drive_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.clock_pull_low || result.data_pull_low) |-> result.busy_res)
		else $error("line driven while link idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> !result.busy_res)
		else $error("done reported while transfer still busy");

endmodule
`default_nettype wire
